>>> hdl/wts_pkg.sv
package wts_pkg;

    localparam int SUM_W = 40;
    localparam int SS_W  = 64;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ROW_LENGTH   = 2'd0;
    localparam logic [1:0] REG_GROUP_SPLIT  = 2'd1;
    localparam logic [1:0] REG_EMPTY_MARKER = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_FLAT = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_M1,
        S_M2,
        S_PASS,
        S_V1A,
        S_V1B,
        S_V2A,
        S_V2B,
        S_WCHK,
        S_ROOT,
        S_QUOT
    } t_state;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_itu_op;

    typedef struct packed {
        logic        start;
        t_itu_op     op;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_itu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_itu_rsp;

endpackage

>>> hdl/wts_itu.sv
module wts_itu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wts_pkg::t_itu_req i_req,
    output wts_pkg::t_itu_rsp o_rsp
);
    import wts_pkg::*;

    logic        r_run;
    logic        r_done;
    t_itu_op     r_op;
    logic [6:0]  r_cnt;
    logic [34:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_src;
    logic [31:0] r_div;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;
    logic [6:0]  last_step;

    // Restoring division takes one dividend bit per step; the root takes two
    // radicand bits per step with the trial value built from the partial root.
    always_comb begin
        if (r_op == OP_SQRT) begin
            rem_sh    = {r_rem[32:0], r_src[63:62]};
            trial     = {r_quo[32:0], 2'b01};
            last_step = 7'd31;
        end else begin
            rem_sh    = {r_rem[33:0], r_src[63]};
            trial     = {3'b000, r_div};
            last_step = 7'd63;
        end
        ge = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_op  <= i_req.op;
                r_cnt <= '0;
                r_rem <= '0;
                r_quo <= '0;
                r_src <= i_req.dividend;
                r_div <= i_req.divisor;
            end else if (r_run) begin
                r_rem <= ge ? (rem_sh - trial) : rem_sh;
                r_quo <= {r_quo[62:0], ge};
                r_src <= (r_op == OP_SQRT) ? {r_src[61:0], 2'b00} : {r_src[62:0], 1'b0};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == last_step) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_quo;

endmodule

>>> hdl/welch_t_statistic_per_row_unit.sv
// Samples are taken one per cycle while busy is low. The sample that ends a row starts the
// row-end sequence: up to seven 64-step divisions and one 32-step root on the shared
// iterative unit plus one pass over the row store. One result per row.
// Reset is synchronous, active low, and restores the register defaults and an empty row.
// The result strobe lasts one cycle; the receiver cannot stall it.
module welch_t_statistic_per_row_unit #(
    parameter int ROW_MAX = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_sample,
    output logic        o_done,
    output logic [31:0] o_t_value,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wts_pkg::*;

    localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int PW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int CW = $clog2(ROW_MAX + 1);

    logic [7:0]  r_row_length;
    logic [6:0]  r_group_split;
    logic [31:0] r_empty_marker;

    logic [31:0] r_mem [ROW_MAX];
    logic [31:0] r_rdata;

    t_state r_state, n_state;

    logic [AW-1:0]           r_pos;
    logic [AW-1:0]           r_last;
    logic [AW-1:0]           r_col;
    logic                    r_issue;
    logic signed [SUM_W-1:0] r_sum1, r_sum2;
    logic [CW-1:0]           r_n1, r_n2;
    logic signed [31:0]      r_m1, r_m2;
    logic [SS_W-1:0]         r_ss1, r_ss2;
    logic [63:0]             r_tmp, r_w1, r_w2;
    logic [47:0]             r_w;
    logic [31:0]             r_root;
    logic                    r_wait;

    logic        r_v1, r_g1, r_v2, r_g2, r_v3, r_g3;
    logic [31:0] r_ad;
    logic [63:0] r_sq;

    logic        r_done;
    logic [31:0] r_t;
    logic [1:0]  r_status;

    t_itu_req itu_req;
    t_itu_rsp itu_rsp;

    logic          accept;
    logic [PW-1:0] len;
    logic          row_end;
    logic          in_grp1;
    logic          counted;
    logic          few;
    logic          arith;
    logic [64:0]   w_sum;
    logic [47:0]   w_clamp;
    logic signed [32:0] diff;
    logic [31:0]   mag;
    logic [63:0]   quot;
    logic signed [32:0] d;
    logic signed [31:0] m_sel;
    logic [PW-1:0] col_ext;
    logic          wr_cfg;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_ROW_LENGTH:   prdata = {24'd0, r_row_length};
            REG_GROUP_SPLIT:  prdata = {25'd0, r_group_split};
            REG_EMPTY_MARKER: prdata = r_empty_marker;
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length   <= 8'd128;
            r_group_split  <= 7'd64;
            r_empty_marker <= 32'd0;
        end else if (wr_cfg) begin
            case (paddr[3:2])
                REG_ROW_LENGTH:   r_row_length   <= pwdata[7:0];
                REG_GROUP_SPLIT:  r_group_split  <= pwdata[6:0];
                REG_EMPTY_MARKER: r_empty_marker <= pwdata;
                default:          ;
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        if (r_row_length == 8'd0) begin
            len = PW'(1);
        end else if (PW'(r_row_length) > PW'(ROW_MAX)) begin
            len = PW'(ROW_MAX);
        end else begin
            len = PW'(r_row_length);
        end
        row_end = (PW'(r_pos) + PW'(1)) >= len;
        in_grp1 = PW'(r_pos) < PW'(r_group_split);
        counted = (i_sample != r_empty_marker);
        few     = (r_n1 < CW'(2)) || (r_n2 < CW'(2));
        col_ext = PW'(r_col);

        w_sum   = {1'b0, r_w1} + {1'b0, r_w2};
        w_clamp = (w_sum > 65'({48{1'b1}})) ? {48{1'b1}} : w_sum[47:0];

        diff = 33'(r_m1) - 33'(r_m2);
        mag  = diff[32] ? 32'(-diff) : diff[31:0];
        quot = itu_rsp.result;

        m_sel = r_g1 ? r_m1 : r_m2;
        d     = 33'($signed(r_rdata)) - 33'(m_sel);
    end

    // Row store: one write port for samples, one registered read port for the second pass.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_pos] <= i_sample;
        end
        r_rdata <= r_mem[r_col];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && row_end) n_state = S_CHECK;
            S_CHECK: n_state = few ? S_IDLE : S_M1;
            S_M1:    if (itu_rsp.done) n_state = S_M2;
            S_M2:    if (itu_rsp.done) n_state = S_PASS;
            S_PASS:  if (!r_issue && !r_v1 && !r_v2 && !r_v3) n_state = S_V1A;
            S_V1A:   if (itu_rsp.done) n_state = S_V1B;
            S_V1B:   if (itu_rsp.done) n_state = S_V2A;
            S_V2A:   if (itu_rsp.done) n_state = S_V2B;
            S_V2B:   if (itu_rsp.done) n_state = S_WCHK;
            S_WCHK:  n_state = (w_clamp == 48'd0) ? S_IDLE : S_ROOT;
            S_ROOT:  if (itu_rsp.done) n_state = S_QUOT;
            S_QUOT:  if (itu_rsp.done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        arith = (r_state == S_M1) || (r_state == S_M2) || (r_state == S_V1A) ||
                (r_state == S_V1B) || (r_state == S_V2A) || (r_state == S_V2B) ||
                (r_state == S_ROOT) || (r_state == S_QUOT);
        itu_req.start    = arith && !r_wait && !itu_rsp.done;
        itu_req.op       = OP_DIV;
        itu_req.dividend = 64'd0;
        itu_req.divisor  = 32'd1;
        case (r_state)
            S_M1: begin
                itu_req.dividend = 64'(r_sum1[SUM_W-1] ? -r_sum1 : r_sum1);
                itu_req.divisor  = 32'(r_n1);
            end
            S_M2: begin
                itu_req.dividend = 64'(r_sum2[SUM_W-1] ? -r_sum2 : r_sum2);
                itu_req.divisor  = 32'(r_n2);
            end
            S_V1A: begin
                itu_req.dividend = r_ss1;
                itu_req.divisor  = 32'(r_n1 - CW'(1));
            end
            S_V1B: begin
                itu_req.dividend = r_tmp;
                itu_req.divisor  = 32'(r_n1);
            end
            S_V2A: begin
                itu_req.dividend = r_ss2;
                itu_req.divisor  = 32'(r_n2 - CW'(1));
            end
            S_V2B: begin
                itu_req.dividend = r_tmp;
                itu_req.divisor  = 32'(r_n2);
            end
            S_ROOT: begin
                itu_req.op       = OP_SQRT;
                itu_req.dividend = {r_w, 16'd0};
            end
            S_QUOT: begin
                itu_req.dividend = {16'd0, mag, 16'd0};
                itu_req.divisor  = r_root;
            end
            default: ;
        endcase
    end

    wts_itu u_itu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (itu_req),
        .o_rsp   (itu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_sum1  <= '0;
            r_sum2  <= '0;
            r_n1    <= '0;
            r_n2    <= '0;
            r_wait  <= 1'b0;
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;

            if (itu_req.start) begin
                r_wait <= 1'b1;
            end else if (itu_rsp.done) begin
                r_wait <= 1'b0;
            end

            if (accept) begin
                if (counted) begin
                    if (in_grp1) begin
                        r_sum1 <= r_sum1 + SUM_W'($signed(i_sample));
                        r_n1   <= r_n1 + CW'(1);
                    end else begin
                        r_sum2 <= r_sum2 + SUM_W'($signed(i_sample));
                        r_n2   <= r_n2 + CW'(1);
                    end
                end
                if (row_end) begin
                    r_last <= r_pos;
                end else begin
                    r_pos <= r_pos + AW'(1);
                end
            end

            case (r_state)
                S_CHECK: begin
                    if (few) begin
                        r_t      <= 32'd0;
                        r_status <= ST_FEW;
                        r_done   <= 1'b1;
                    end
                end
                S_M1: begin
                    if (itu_rsp.done) begin
                        r_m1 <= r_sum1[SUM_W-1] ? -$signed(quot[31:0]) : $signed(quot[31:0]);
                    end
                end
                S_M2: begin
                    if (itu_rsp.done) begin
                        r_m2    <= r_sum2[SUM_W-1] ? -$signed(quot[31:0]) : $signed(quot[31:0]);
                        r_col   <= '0;
                        r_issue <= 1'b1;
                        r_ss1   <= '0;
                        r_ss2   <= '0;
                    end
                end
                S_V1A, S_V2A: begin
                    if (itu_rsp.done) r_tmp <= quot;
                end
                S_V1B: begin
                    if (itu_rsp.done) r_w1 <= quot;
                end
                S_V2B: begin
                    if (itu_rsp.done) r_w2 <= quot;
                end
                S_WCHK: begin
                    r_w <= w_clamp;
                    if (w_clamp == 48'd0) begin
                        r_t      <= 32'd0;
                        r_status <= ST_FLAT;
                        r_done   <= 1'b1;
                    end
                end
                S_ROOT: begin
                    if (itu_rsp.done) r_root <= quot[31:0];
                end
                S_QUOT: begin
                    if (itu_rsp.done) begin
                        r_done <= 1'b1;
                        if (diff[32]) begin
                            if (quot > 64'h8000_0000) begin
                                r_t      <= 32'h8000_0000;
                                r_status <= ST_SAT;
                            end else begin
                                r_t      <= 32'(-quot[31:0]);
                                r_status <= ST_OK;
                            end
                        end else begin
                            if (quot > 64'h7FFF_FFFF) begin
                                r_t      <= 32'h7FFF_FFFF;
                                r_status <= ST_SAT;
                            end else begin
                                r_t      <= quot[31:0];
                                r_status <= ST_OK;
                            end
                        end
                    end
                end
                default: ;
            endcase

            // Second pass: address, read data, absolute deviation, square, accumulate.
            r_v1 <= 1'b0;
            if (r_state == S_PASS && r_issue) begin
                r_v1 <= 1'b1;
                r_g1 <= col_ext < PW'(r_group_split);
                if (r_col == r_last) begin
                    r_issue <= 1'b0;
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
            r_v2 <= r_v1 && (r_rdata != r_empty_marker);
            r_g2 <= r_g1;
            r_ad <= d[32] ? 32'(-d) : d[31:0];
            r_v3 <= r_v2;
            r_g3 <= r_g2;
            r_sq <= 64'(r_ad) * 64'(r_ad);
            if (r_v3) begin
                if (r_g3) r_ss1 <= r_ss1 + {16'd0, r_sq[63:16]};
                else      r_ss2 <= r_ss2 + {16'd0, r_sq[63:16]};
            end

            // A finished row leaves the accumulators clear for the next one.
            if (n_state == S_IDLE && r_state != S_IDLE) begin
                r_pos  <= '0;
                r_sum1 <= '0;
                r_sum2 <= '0;
                r_n1   <= '0;
                r_n2   <= '0;
            end
        end
    end

    assign o_done    = r_done;
    assign o_t_value = r_t;
    assign o_status  = r_status;

endmodule

>>> hdl/wts_checker.sv
module wts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_t_value,
    input logic [1:0]  o_status
);
    import wts_pkg::*;

    // A result always closes a busy row-end sequence.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a preceding row-end sequence");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("one row produced two results");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_FEW || o_status == ST_FLAT) |-> o_t_value == 32'd0)
        else $error("flagged result carries a nonzero statistic");

endmodule

bind welch_t_statistic_per_row_unit wts_checker u_wts_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .busy      (busy),
    .o_done    (o_done),
    .o_t_value (o_t_value),
    .o_status  (o_status)
);

>>> verif/wts_checker.sv
module wts_scoreboard #(
    parameter int ROW_MAX = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_sample,
    input  logic        i_done,
    input  logic [31:0] i_t_value,
    input  logic [1:0]  i_status,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);
    import wts_pkg::*;

    localparam int EXP_DEPTH = 8;

    typedef struct {
        logic [31:0] t_value;
        logic [1:0]  status;
    } t_row_result;

    t_row_result exp_fifo [EXP_DEPTH];
    int          exp_wr, exp_rd, exp_count;

    logic [7:0]  row_len_r;
    logic [6:0]  split_r;
    logic [31:0] marker_r;
    logic [31:0] row_mem [ROW_MAX];
    int unsigned col_pos;
    longint      sum_one, sum_two;
    int unsigned cnt_one, cnt_two;

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    // Folds one accepted sample into the row and, at the row end, computes the statistic.
    task automatic take_sample(logic [31:0] x);
        int unsigned len, pos, c;
        longint      m1, m2, diff, d;
        logic [63:0] ss1, ss2, w, r, mag, q, ad, n1, n2;
        t_row_result res;
        len = row_len_r;
        if (len == 0) len = 1;
        if (len > ROW_MAX) len = ROW_MAX;
        pos = col_pos;
        if (pos >= ROW_MAX) pos = ROW_MAX - 1;
        row_mem[pos] = x;
        if (x != marker_r) begin
            if (pos < split_r) begin
                sum_one += longint'($signed(x));
                cnt_one++;
            end else begin
                sum_two += longint'($signed(x));
                cnt_two++;
            end
        end
        if (pos + 1 < len) begin
            col_pos = pos + 1;
            return;
        end
        res.t_value = '0;
        res.status = ST_OK;
        if (cnt_one < 2 || cnt_two < 2) begin
            res.status = ST_FEW;
        end else begin
            m1 = sum_one / longint'(cnt_one);
            m2 = sum_two / longint'(cnt_two);
            ss1 = 0;
            ss2 = 0;
            for (c = 0; c <= pos; c++) begin
                if (row_mem[c] != marker_r) begin
                    d = longint'($signed(row_mem[c])) - ((c < split_r) ? m1 : m2);
                    ad = (d < 0) ? 64'(-d) : 64'(d);
                    if (c < split_r) ss1 += (ad * ad) >> 16;
                    else ss2 += (ad * ad) >> 16;
                end
            end
            n1 = cnt_one;
            n2 = cnt_two;
            w = (ss1 / (n1 - 1)) / n1 + (ss2 / (n2 - 1)) / n2;
            if (w > ((64'h1 << 48) - 1)) w = (64'h1 << 48) - 1;
            if (w == 0) begin
                res.status = ST_FLAT;
            end else begin
                r = floor_root(w << 16);
                diff = m1 - m2;
                mag = (diff < 0) ? 64'(-diff) : 64'(diff);
                q = (mag << 16) / r;
                if (diff < 0) begin
                    if (q > 64'd2147483648) begin
                        q = 64'd2147483648;
                        res.status = ST_SAT;
                    end
                    res.t_value = 32'(-q);
                end else begin
                    if (q > 64'd2147483647) begin
                        q = 64'd2147483647;
                        res.status = ST_SAT;
                    end
                    res.t_value = q[31:0];
                end
            end
        end
        if (exp_count == EXP_DEPTH) begin
            report("expected-result buffer overflow");
        end else begin
            exp_fifo[exp_wr] = res;
            exp_wr = (exp_wr + 1) % EXP_DEPTH;
            exp_count++;
        end
        col_pos = 0;
        sum_one = 0;
        sum_two = 0;
        cnt_one = 0;
        cnt_two = 0;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        exp_wr = 0;
        exp_rd = 0;
        exp_count = 0;
    end

    always @(posedge i_clk) begin
        t_row_result exp_res;
        if (!i_rst_n) begin
            row_len_r = 8'd128;
            split_r = 7'd64;
            marker_r = '0;
            col_pos = 0;
            sum_one = 0;
            sum_two = 0;
            cnt_one = 0;
            cnt_two = 0;
            exp_wr = 0;
            exp_rd = 0;
            exp_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_ROW_LENGTH:   row_len_r = i_pwdata[7:0];
                    REG_GROUP_SPLIT:  split_r = i_pwdata[6:0];
                    REG_EMPTY_MARKER: marker_r = i_pwdata;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) take_sample(i_sample);
            if (i_done) begin
                if (exp_count == 0) begin
                    report($sformatf("unexpected result t=%h status=%0d", i_t_value, i_status));
                end else begin
                    exp_res = exp_fifo[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_count--;
                    if (i_t_value !== exp_res.t_value)
                        report($sformatf("t_value %h, expected %h", i_t_value, exp_res.t_value));
                    if (i_status !== exp_res.status)
                        report($sformatf("status %0d, expected %0d", i_status, exp_res.status));
                end
            end
        end
        o_pending = exp_count;
    end

endmodule

>>> verif/tb.sv
module tb;
    import wts_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_sample = '0;
    logic        o_done;
    logic [31:0] o_t_value;
    logic [1:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          items_sent = 0;
    int          burst_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    welch_t_statistic_per_row_unit #(.ROW_MAX(128)) i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_sample, .o_done, .o_t_value, .o_status,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    wts_scoreboard #(.ROW_MAX(128)) i_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_sample,
        .i_done(o_done), .i_t_value(o_t_value), .i_status(o_status),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready), .o_errors(errors), .o_pending(pending)
    );

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        while (!pready) @(negedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits for every row result, then lets the row-end sequence drain.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic configure(logic [7:0] len, logic [6:0] split, logic [31:0] marker);
        settle();
        reg_write(REG_ROW_LENGTH, {$urandom} & 32'hFFFF_FF00 | len);
        reg_write(REG_GROUP_SPLIT, {$urandom} & 32'hFFFF_FF80 | split);
        reg_write(REG_EMPTY_MARKER, marker);
    endtask

    // One sample transfer; start stays high across back-to-back transfers of a burst.
    task automatic send(logic [31:0] x);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start <= 1'b1;
        i_sample <= x;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_row4(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
        send(a);
        send(b);
        send(c);
        send(d);
    endtask

    initial begin
        int unsigned len, split, spread, pick, k;
        logic [31:0] marker, base1, base2, v;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows.
        configure(8'd4, 7'd2, 32'h0);
        send_row4(32'h0001_0000, 32'h0003_0000, 32'h0005_0000, 32'h0009_0000);
        send_row4(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        send_row4(32'h0, 32'h200, 32'h7F00_0000, 32'h7F00_0000);
        send_row4(32'h7F00_0000, 32'h7F00_0000, 32'h0, 32'h200);
        send_row4(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        configure(8'd4, 7'd2, 32'h0001_2345);
        send_row4(32'h0001_2345, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
        configure(8'd4, 7'd0, 32'h0);
        send_row4(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
        configure(8'd0, 7'd1, 32'h0);
        send(32'h1234_5678);
        // A row cut short by a smaller length written mid row.
        configure(8'd8, 7'd2, 32'h0);
        for (k = 0; k < 5; k++) send(32'h0001_0000 * (k + 1) + k * 7);
        configure(8'd3, 7'd2, 32'h0);
        send(32'h0009_0000);

        // Random rows across several settings.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: len = 255;
                1: len = 2;
                2: len = 128;
                default: len = $urandom_range(3, 20);
            endcase
            pick = $urandom_range(0, 9);
            if (pick == 0) split = 0;
            else if (pick == 1) split = 127;
            else if (pick == 2) split = len;
            else split = $urandom_range(1, (len > 128 ? 128 : len) - 1);
            case ($urandom_range(0, 3))
                0: marker = 32'h0;
                1: marker = 32'h8000_0000;
                2: marker = 32'h7FFF_FFFF;
                default: marker = $urandom;
            endcase
            configure(len[7:0], split[6:0], marker);
            k = 0;
            while (k < ((len >= 128) ? 128 : 75)) begin
                base1 = $signed($urandom) >>> $urandom_range(1, 12);
                base2 = ($urandom_range(0, 3) == 0) ? base1 : $signed($urandom) >>> $urandom_range(1, 12);
                spread = ($urandom_range(0, 9) == 0) ? 0 : (1 << $urandom_range(2, 22));
                for (int c = 0; c < ((len > 128) ? 128 : (len == 0 ? 1 : len)); c++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 7) v = marker;
                    else if (pick < 13) v = $urandom;
                    else v = ((c < split) ? base1 : base2) + $urandom_range(0, spread);
                    send(v);
                    k++;
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        settle();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("** welch_t_statistic_per_row_unit: PASSED **");
        end else begin
            $display("** welch_t_statistic_per_row_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** welch_t_statistic_per_row_unit: FAILED **");
        $finish;
    end

endmodule
